// ----- hdl/hvs_pkg.sv -----
package hvs_pkg;

    // Vowel weighting selectors
    localparam logic [1:0] VOWEL_A = 2'd0;
    localparam logic [1:0] VOWEL_B = 2'd1;

    localparam int unsigned RATE_RESET    = 16000;
    localparam int unsigned ATTACK_DIV    = 25;
    localparam int unsigned RELEASE_DIV   = 18;
    localparam int unsigned ATTACK_RESET  = RATE_RESET / ATTACK_DIV;
    localparam int unsigned RELEASE_RESET = RATE_RESET / RELEASE_DIV;

    // floor(x / 25) and floor(x / 18) for 16-bit x as (x * MUL) >> 21
    localparam int unsigned RECIP_SHIFT = 21;
    localparam int unsigned ATTACK_MUL  = 83887;
    localparam int unsigned RELEASE_MUL = 116509;

    localparam int unsigned ENV_W     = 12;
    localparam int unsigned ENV_FULL  = 32767;
    localparam int          CLAMP_LIM = 28000;
    localparam int unsigned MIX_DIV   = 15;
    localparam int unsigned OUT_DIV   = 3;

    localparam logic signed [15:0] SINE_Q15 [64] = '{
        16'sd0, 16'sd3212, 16'sd6393, 16'sd9512, 16'sd12539, 16'sd15446, 16'sd18204,
        16'sd20787, 16'sd23170, 16'sd25330, 16'sd27245, 16'sd28898, 16'sd30273,
        16'sd31356, 16'sd32137, 16'sd32609, 16'sd32767, 16'sd32609, 16'sd32137,
        16'sd31356, 16'sd30273, 16'sd28898, 16'sd27245, 16'sd25330, 16'sd23170,
        16'sd20787, 16'sd18204, 16'sd15446, 16'sd12539, 16'sd9512, 16'sd6393,
        16'sd3212, 16'sd0, -16'sd3212, -16'sd6393, -16'sd9512, -16'sd12539,
        -16'sd15446, -16'sd18204, -16'sd20787, -16'sd23170, -16'sd25330,
        -16'sd27245, -16'sd28898, -16'sd30273, -16'sd31356, -16'sd32137,
        -16'sd32609, -16'sd32767, -16'sd32609, -16'sd32137, -16'sd31356,
        -16'sd30273, -16'sd28898, -16'sd27245, -16'sd25330, -16'sd23170,
        -16'sd20787, -16'sd18204, -16'sd15446, -16'sd12539, -16'sd9512,
        -16'sd6393, -16'sd3212
    };

endpackage

// ----- hdl/hvs_div.sv -----
module hvs_div #(
    parameter int NW = 39,
    parameter int DW = 22
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo
);

    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] num_reg;
    logic [DW-1:0] den_reg;
    logic [DW-1:0] rem_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [DW:0]   trial;
    logic          fit;
    logic [DW-1:0] rem_next;
    logic [NW-1:0] num_next;

    // One quotient bit per cycle: shift in the next dividend bit, try the subtract
    assign trial    = {rem_reg, num_reg[NW-1]};
    assign fit      = trial >= {1'b0, den_reg};
    assign rem_next = fit ? DW'(trial - {1'b0, den_reg}) : trial[DW-1:0];
    assign num_next = {num_reg[NW-2:0], fit};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CW'(NW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quo  = num_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg) else $error("divide started while busy");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg)) else $error("done without a running divide");
    a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg != '0) else $error("busy with empty bit count");

endmodule

// ----- hdl/hvs_mix.sv -----
module hvs_mix (
    input  logic               clk,
    input  logic [15:0]        phase,
    input  logic [1:0]         vowel,
    output logic signed [20:0] mix_sum
);

    logic [15:0]        ph2;
    logic [15:0]        ph3;
    logic [15:0]        ph4;
    logic signed [20:0] e1;
    logic signed [20:0] e2;
    logic signed [20:0] e3;
    logic signed [20:0] e4;
    logic signed [20:0] sum_next;
    logic signed [20:0] sum_reg;

    assign ph2 = {phase[14:0], 1'b0};
    assign ph3 = phase + ph2;
    assign ph4 = {phase[13:0], 2'b00};

    // Harmonic lookups at phase bits 15:10
    assign e1 = 21'(hvs_pkg::SINE_Q15[phase[15:10]]);
    assign e2 = 21'(hvs_pkg::SINE_Q15[ph2[15:10]]);
    assign e3 = 21'(hvs_pkg::SINE_Q15[ph3[15:10]]);
    assign e4 = 21'(hvs_pkg::SINE_Q15[ph4[15:10]]);

    always_comb
    begin
        case (vowel)
            hvs_pkg::VOWEL_A: sum_next = e1 * 21'sd9 + e2 * 21'sd4 + e3 * 21'sd2 + e4;
            hvs_pkg::VOWEL_B: sum_next = e1 * 21'sd6 + e2 * 21'sd2 + e3 * 21'sd5
                                         + e4 * 21'sd2;
            default:          sum_next = e1 * 21'sd7 + e2 * 21'sd5 + e3 + e4 * 21'sd3;
        endcase
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
    end

    assign mix_sum = sum_reg;

endmodule

// ----- hdl/harmonic_voice_synth.sv -----
// Harmonic voice synthesizer: one signed 16-bit PCM sample per request.
//
// Channels:
//   s_*   request stream; tdata carries pitch_start, pitch_end, seg_length and
//         seg_position, tuser carries vowel and restart.
//   m_*   sample stream, one sample per request, in request order.
//   cfg_* write of sample_rate; the attack and release lengths are derived on
//         the write. Write only while no request is in flight.
// Timing: one request is in work at a time. Each request runs up to five
// passes of a bit-serial restoring divider (glide, phase step, envelope,
// vowel /15, final /3), each a launch step, the bit-serial shifts and a done
// step, plus an accept, a scale and an output step. Each skipped divide
// (zero length, zero rate, flat envelope, /16 vowels) bypasses the divider.
// The divider sets the rate.
// Reset: phase accumulator cleared, sample_rate = 16000, no sample pending.
// Stall: the finished sample sits in the output register; the next request
// is taken and worked on, and holds in its last step until the output frees.
module harmonic_voice_synth #(
    parameter int SEG_COUNT_BITS = 22
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    // [15:0] pitch_start, [31:16] pitch_end, then seg_length, seg_position, zero pad
    input  logic [((32 + 2*SEG_COUNT_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // [1:0] vowel, [2] restart
    input  logic [2:0]                                 s_tuser,
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    // [15:0] sample
    output logic [15:0]                                m_tdata,
    input  logic                                       cfg_valid,
    output logic                                       cfg_ready,
    input  logic [15:0]                                cfg_data
);

    localparam int SEG = SEG_COUNT_BITS;
    localparam int NW  = SEG + 17;
    localparam int DW  = SEG;
    localparam int EW  = hvs_pkg::ENV_W;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_GLIDE  = 8'b0000_0010,
        ST_STEP   = 8'b0000_0100,
        ST_ENV    = 8'b0000_1000,
        ST_MIXDIV = 8'b0001_0000,
        ST_SCALE  = 8'b0010_0000,
        ST_DIV3   = 8'b0100_0000,
        ST_OUT    = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   issued_reg, issued_next;

    logic [15:0]        fs_reg;
    logic [15:0]        f0_reg;
    logic [1:0]         vowel_reg;
    logic [SEG-1:0]     len_reg;
    logic [SEG-1:0]     pos_reg;
    logic               neg_reg;
    logic [16:0]        mag_reg;
    logic [15:0]        phase_reg;
    logic [15:0]        rate_reg;
    logic [EW-1:0]      attack_reg;
    logic [EW-1:0]      release_reg;
    logic [15:0]        env_reg;
    logic signed [16:0] mixed_reg;
    logic signed [32:0] prod_reg;
    logic [15:0]        res_reg;
    logic [15:0]        out_data_reg;
    logic               out_valid_reg;

    logic [15:0]        in_fs;
    logic [15:0]        in_fe;
    logic [SEG-1:0]     in_len;
    logic [SEG-1:0]     in_pos;
    logic signed [16:0] in_diff;
    logic               accept;

    logic               div_start;
    logic [NW-1:0]      div_num;
    logic [DW-1:0]      div_den;
    logic               div_done;
    logic [NW-1:0]      div_quo;
    logic               div_need;

    logic               att_hit;
    logic               rel_hit;
    logic [SEG-1:0]     rel_x;
    logic [SEG-1:0]     env_x;

    logic signed [20:0] mix_sum;
    logic               mix_neg;
    logic [19:0]        mix_mag;
    logic signed [20:0] mix_by16;

    logic signed [17:0] scaled;
    logic [16:0]        scaled_mag;
    logic signed [17:0] div3_res;
    logic [33:0]        att_prod;
    logic [33:0]        rel_prod;

    // Unpack the request
    assign in_fs   = s_tdata[15:0];
    assign in_fe   = s_tdata[31:16];
    assign in_len  = s_tdata[32 +: SEG];
    assign in_pos  = s_tdata[32 + SEG +: SEG];
    assign in_diff = $signed({1'b0, in_fe}) - $signed({1'b0, in_fs});

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Envelope branch selection
    assign att_hit = pos_reg < SEG'(attack_reg);
    assign rel_x   = len_reg - pos_reg;
    assign rel_hit = rel_x < SEG'(release_reg);
    assign env_x   = att_hit ? pos_reg : rel_x;

    // Vowel mix magnitude and the /16 truncating path
    assign mix_neg  = mix_sum[20];
    assign mix_mag  = mix_neg ? 20'(-mix_sum) : mix_sum[19:0];
    assign mix_by16 = (mix_sum + (mix_neg ? 21'sd15 : 21'sd0)) >>> 4;

    // Floor shift by 15 of the enveloped mix, then magnitude for /3
    assign scaled     = 18'(prod_reg >>> 15);
    assign scaled_mag = scaled[17] ? 17'(-scaled) : scaled[16:0];
    assign div3_res   = scaled[17] ? -$signed({1'b0, div_quo[16:0]})
                                   : $signed({1'b0, div_quo[16:0]});

    assign att_prod = 34'(cfg_data) * 34'(hvs_pkg::ATTACK_MUL);
    assign rel_prod = 34'(cfg_data) * 34'(hvs_pkg::RELEASE_MUL);

    // Divider operands per step
    always_comb
    begin
        div_num  = '0;
        div_den  = '0;
        div_need = 1'b0;
        case (state_reg)
            ST_GLIDE:
            begin
                div_need = len_reg != '0;
                div_num  = NW'(mag_reg) * NW'(pos_reg);
                div_den  = len_reg;
            end
            ST_STEP:
            begin
                div_need = rate_reg != '0;
                div_num  = NW'({f0_reg, 16'h0000});
                div_den  = DW'(rate_reg);
            end
            ST_ENV:
            begin
                div_need = att_hit || rel_hit;
                div_num  = (NW'(env_x) << 15) - NW'(env_x);
                div_den  = att_hit ? DW'(attack_reg) : DW'(release_reg);
            end
            ST_MIXDIV:
            begin
                div_need = vowel_reg == hvs_pkg::VOWEL_B;
                div_num  = NW'(mix_mag);
                div_den  = DW'(hvs_pkg::MIX_DIV);
            end
            ST_DIV3:
            begin
                div_need = 1'b1;
                div_num  = NW'(scaled_mag);
                div_den  = DW'(hvs_pkg::OUT_DIV);
            end
            default:
            begin
                div_need = 1'b0;
            end
        endcase
    end

    assign div_start = div_need && !issued_reg;

    // Step sequencer: launch a divide, wait for it, or skip straight on
    always_comb
    begin
        state_next  = state_reg;
        issued_next = issued_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_GLIDE;
                end
            end
            ST_GLIDE, ST_STEP, ST_ENV, ST_MIXDIV, ST_DIV3:
            begin
                if (div_start)
                begin
                    issued_next = 1'b1;
                end
                else if (!div_need || div_done)
                begin
                    issued_next = 1'b0;
                    case (state_reg)
                        ST_GLIDE:  state_next = ST_STEP;
                        ST_STEP:   state_next = ST_ENV;
                        ST_ENV:    state_next = ST_MIXDIV;
                        ST_MIXDIV: state_next = ST_SCALE;
                        default:   state_next = ST_OUT;
                    endcase
                end
            end
            ST_SCALE:
            begin
                state_next = ST_DIV3;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    wire step_end = !div_start && (!div_need || div_done);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issued_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= '0;
            rate_reg      <= 16'(hvs_pkg::RATE_RESET);
            attack_reg    <= EW'(hvs_pkg::ATTACK_RESET);
            release_reg   <= EW'(hvs_pkg::RELEASE_RESET);
        end
        else
        begin
            state_reg  <= state_next;
            issued_reg <= issued_next;

            if (cfg_valid && cfg_ready)
            begin
                rate_reg    <= cfg_data;
                attack_reg  <= EW'(att_prod >> hvs_pkg::RECIP_SHIFT);
                release_reg <= EW'(rel_prod >> hvs_pkg::RECIP_SHIFT);
            end

            // Restart clears the phase ahead of this sample's step
            if (accept && s_tuser[2])
            begin
                phase_reg <= '0;
            end
            else if (state_reg == ST_STEP && step_end && div_need)
            begin
                phase_reg <= phase_reg + div_quo[15:0];
            end

            if (state_reg == ST_OUT && (!out_valid_reg || m_tready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath holding registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fs_reg    <= in_fs;
            vowel_reg <= s_tuser[1:0];
            len_reg   <= in_len;
            pos_reg   <= (in_pos > in_len) ? in_len : in_pos;
            neg_reg   <= in_diff[16];
            mag_reg   <= in_diff[16] ? 17'(-in_diff) : 17'(in_diff);
        end
        case (state_reg)
            ST_GLIDE:
            begin
                if (step_end)
                begin
                    if (!div_need)
                        f0_reg <= fs_reg;
                    else if (neg_reg)
                        f0_reg <= fs_reg - div_quo[15:0];
                    else
                        f0_reg <= fs_reg + div_quo[15:0];
                end
            end
            ST_ENV:
            begin
                if (step_end)
                    env_reg <= div_need ? div_quo[15:0] : 16'(hvs_pkg::ENV_FULL);
            end
            ST_MIXDIV:
            begin
                if (step_end)
                begin
                    if (!div_need)
                        mixed_reg <= 17'(mix_by16);
                    else if (mix_neg)
                        mixed_reg <= -$signed({1'b0, div_quo[15:0]});
                    else
                        mixed_reg <= $signed({1'b0, div_quo[15:0]});
                end
            end
            ST_SCALE:
            begin
                prod_reg <= 33'(mixed_reg) * $signed({17'h0, env_reg});
            end
            ST_DIV3:
            begin
                if (step_end)
                begin
                    if (div3_res > 18'(hvs_pkg::CLAMP_LIM))
                        res_reg <= 16'(hvs_pkg::CLAMP_LIM);
                    else if (div3_res < -18'(hvs_pkg::CLAMP_LIM))
                        res_reg <= 16'(-hvs_pkg::CLAMP_LIM);
                    else
                        res_reg <= div3_res[15:0];
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_tready)
                    out_data_reg <= res_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    hvs_div #(
        .NW(NW),
        .DW(DW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    hvs_mix u_mix (
        .clk     (clk),
        .phase   (phase_reg),
        .vowel   (vowel_reg),
        .mix_sum (mix_sum)
    );

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != ST_IDLE) else $error("accept left sequencer idle");
    a_out_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == ST_OUT))
        else $error("sample shown outside final step");
    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata) <= 16'sd28000 && $signed(m_tdata) >= -16'sd28000))
        else $error("sample outside clamp range");

endmodule
